// ===== design/kf_pkg.sv =====
// Shared types and constants for the scalar Kalman measurement fusion block.
`default_nettype none
package kf_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int VAL_W         = 32;
  localparam int VAR_W         = 31;
  localparam int MA_W          = 33;
  localparam int MB_W          = 32;
  localparam int PR_W          = MA_W + MB_W;
  localparam int ADDR_W        = 5;
  localparam int APB_W         = 32;

  localparam logic [2:0] REG_PROCESS_NOISE   = 3'd0;
  localparam logic [2:0] REG_NOISE_FIRST     = 3'd1;
  localparam logic [2:0] REG_NOISE_SECOND    = 3'd2;
  localparam logic [2:0] REG_SINGLE_SENSOR   = 3'd3;
  localparam logic [2:0] REG_INIT_COVARIANCE = 3'd4;

  localparam logic [VAR_W-1:0] MAX31    = {VAR_W{1'b1}};
  localparam logic [VAR_W-1:0] RST_Q    = 31'd66;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SGL,
    S_N0,
    S_N1,
    S_N2,
    S_DET,
    S_DST,
    S_DIV0,
    S_DIV1,
    S_K0,
    S_K1,
    S_ACC,
    S_VAR,
    S_OUT
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

// ===== design/kf_mul.sv =====
// Shared signed multiplier with a registered product.
`default_nettype none
module kf_mul
  import kf_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic signed [MA_W-1:0] a,
  input  wire logic signed [MB_W-1:0] b,
  output logic signed [PR_W-1:0]      p_r
);

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

endmodule
`default_nettype wire

// ===== design/kf_div.sv =====
// Restoring divider that yields one quotient bit per cycle for num <= den.
`default_nettype none
module kf_div
  import kf_pkg::*;
#(
  parameter int NUM_W = 48,
  parameter int Q_W   = 17
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [NUM_W-1:0] den,
  output logic [Q_W-1:0]        q_r,
  output div_stat_t             stat
);

  localparam int CNT_W = $clog2(Q_W + 1);

  logic [NUM_W:0]   rem_r;
  logic [NUM_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [NUM_W+1:0] diff_nxt;
  logic             bit_nxt;
  logic [NUM_W:0]   rsel_nxt;

  always_comb begin
    diff_nxt = {1'b0, rem_r} - {2'b00, den_r};
    bit_nxt  = ~diff_nxt[NUM_W+1];
    rsel_nxt = bit_nxt ? diff_nxt[NUM_W:0] : rem_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      rem_r <= {1'b0, num};
      den_r <= den;
      q_r   <= '0;
      cnt_r <= CNT_W'(Q_W);
    end else if (busy_r) begin
      // The remainder stays below den, so its top bit is free for the shift.
      rem_r <= {rsel_nxt[NUM_W-1:0], 1'b0};
      q_r   <= {q_r[Q_W-2:0], bit_nxt};
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule
`default_nettype wire

// ===== design/scalar_kalman_measurement_fusion.sv =====
// Top level of the scalar Kalman filter that fuses one or two measurements.
// One transaction produces one result. A clear goes from acceptance straight to the
// result state; a measurement update runs the multiplier and divider steps, with both
// sensors fused or with one sensor. A zero divisor skips the divider and makes the update
// shorter. The update time is set by the bit-serial gain divider, which runs twice per
// update with both sensors and once with one, and by the single shared multiplier that
// every product passes through. in_ready is high only while the sequencer is idle.
// Estimates are signed and variances unsigned fixed point with FRAC_BITS fraction bits; a
// zero divisor saturates the gain and raises div_saturated.
`default_nettype none
module scalar_kalman_measurement_fusion
  import kf_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [ADDR_W-1:0]       paddr,
  input  wire logic [APB_W-1:0]        pwdata,
  output logic [APB_W-1:0]             prdata,
  output logic                         pready,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic                    in_kind,
  input  wire logic signed [VAL_W-1:0] in_meas_first,
  input  wire logic signed [VAL_W-1:0] in_meas_second,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic signed [VAL_W-1:0]      out_estimate,
  output logic [VAR_W-1:0]             out_variance,
  output logic                         out_div_saturated
);

  localparam int NW = 62 - FRAC_BITS;
  localparam int DW = NW + 2;
  localparam int KW = FRAC_BITS + 1;
  localparam logic [PR_W-1:0] HALF_P = PR_W'(1) << (FRAC_BITS - 1);
  localparam logic [61:0]     HALF_N = 62'(1) << (FRAC_BITS - 1);
  localparam logic [KW-1:0]   ONE_K  = KW'(1) << FRAC_BITS;
  localparam logic [KW-1:0]   HALF_K = KW'(1) << (FRAC_BITS - 1);
  localparam logic [VAR_W-1:0] RST_ONE = VAR_W'(1) << FRAC_BITS;

  // Configuration registers.
  logic [VAR_W-1:0] q_r, r0_r, r1_r, icov_r;
  logic             single_r;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r      <= RST_Q;
      r0_r     <= RST_ONE;
      r1_r     <= RST_ONE;
      single_r <= 1'b0;
      icov_r   <= RST_ONE;
    end else if (wr_en) begin
      case (paddr[4:2])
        REG_PROCESS_NOISE:   q_r      <= pwdata[VAR_W-1:0];
        REG_NOISE_FIRST:     r0_r     <= pwdata[VAR_W-1:0];
        REG_NOISE_SECOND:    r1_r     <= pwdata[VAR_W-1:0];
        REG_SINGLE_SENSOR:   single_r <= pwdata[0];
        REG_INIT_COVARIANCE: icov_r   <= pwdata[VAR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_PROCESS_NOISE:   prdata = {1'b0, q_r};
      REG_NOISE_FIRST:     prdata = {1'b0, r0_r};
      REG_NOISE_SECOND:    prdata = {1'b0, r1_r};
      REG_SINGLE_SENSOR:   prdata = {31'd0, single_r};
      REG_INIT_COVARIANCE: prdata = {1'b0, icov_r};
      default:             prdata = '0;
    endcase
  end

  // Filter state and working registers.
  state_t                 state_r, state_nxt;
  logic signed [VAL_W-1:0] est_r;
  logic [VAR_W-1:0]        var_r;
  logic [VAR_W-1:0]        pp_r;
  logic signed [32:0]      y0_r, y1_r;
  logic [NW-1:0]           n0_r, n1_r;
  logic [DW-1:0]           det_r;
  logic [KW-1:0]           k0_r, k1_r;
  logic signed [PR_W-1:0]  acc_r;
  logic                    sat_r;

  logic signed [MA_W-1:0]  mul_a;
  logic signed [MB_W-1:0]  mul_b;
  logic signed [PR_W-1:0]  prod;
  logic                    div_start;
  logic [DW-1:0]           div_num, div_den;
  logic [KW-1:0]           div_q;
  div_stat_t               div_st;

  logic [31:0]             pp_sum;
  logic [VAR_W-1:0]        pp_nxt;
  logic [31:0]             s_sum;
  logic [NW-1:0]           rnd_n;
  logic [KW-1:0]           fac;
  logic signed [PR_W-1:0]  est_sum;
  logic [PR_W-1:0]         var_w;
  logic                    accept;

  kf_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (prod)
  );

  kf_div #(
    .NUM_W (DW),
    .Q_W   (KW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .q_r   (div_q),
    .stat  (div_st)
  );

  always_comb begin
    pp_sum  = {1'b0, var_r} + {1'b0, q_r};
    pp_nxt  = pp_sum[31] ? MAX31 : pp_sum[VAR_W-1:0];
    s_sum   = {1'b0, pp_r} + {1'b0, r0_r};
    rnd_n   = NW'((prod[61:0] + HALF_N) >> FRAC_BITS);
    fac     = ONE_K - k0_r - k1_r;
    est_sum = PR_W'(est_r) + ((acc_r + $signed(HALF_P)) >>> FRAC_BITS);
    var_w   = PR_W'(prod) + HALF_P;
  end

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);

  // Sequencer: next state, multiplier operands and divider start.
  always_comb begin
    state_nxt = state_r;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_kind) begin
            state_nxt = S_OUT;
          end else begin
            state_nxt = single_r ? S_SGL : S_N0;
          end
        end
      end
      S_SGL: begin
        div_num = DW'(pp_r);
        div_den = DW'(s_sum);
        if (s_sum != 32'd0) begin
          div_start = 1'b1;
          state_nxt = S_DIV0;
        end else begin
          state_nxt = S_K0;
        end
      end
      S_N0: begin
        mul_a     = MA_W'(pp_r);
        mul_b     = MB_W'(r1_r);
        state_nxt = S_N1;
      end
      S_N1: begin
        mul_a     = MA_W'(pp_r);
        mul_b     = MB_W'(r0_r);
        state_nxt = S_N2;
      end
      S_N2: begin
        mul_a     = MA_W'(r0_r);
        mul_b     = MB_W'(r1_r);
        state_nxt = S_DET;
      end
      S_DET: state_nxt = S_DST;
      S_DST: begin
        div_num = DW'(n0_r);
        div_den = det_r;
        if (det_r != '0) begin
          div_start = 1'b1;
          state_nxt = S_DIV0;
        end else begin
          state_nxt = S_K0;
        end
      end
      S_DIV0: begin
        div_num = DW'(n1_r);
        div_den = det_r;
        if (div_st.done) begin
          if (single_r) begin
            state_nxt = S_K0;
          end else begin
            div_start = 1'b1;
            state_nxt = S_DIV1;
          end
        end
      end
      S_DIV1: begin
        if (div_st.done) begin
          state_nxt = S_K0;
        end
      end
      S_K0: begin
        mul_a     = y0_r;
        mul_b     = MB_W'(k0_r);
        state_nxt = S_K1;
      end
      S_K1: begin
        mul_a     = y1_r;
        mul_b     = MB_W'(k1_r);
        state_nxt = S_ACC;
      end
      S_ACC: begin
        mul_a     = MA_W'(pp_r);
        mul_b     = MB_W'(fac);
        state_nxt = S_VAR;
      end
      S_VAR: state_nxt = S_OUT;
      S_OUT: begin
        if (!out_valid || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      est_r     <= '0;
      var_r     <= RST_ONE;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid && out_ready && state_r != S_OUT) begin
        out_valid <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept && in_kind) begin
            est_r <= in_meas_first;
            var_r <= icov_r;
          end
        end
        S_VAR: begin
          if (est_sum[PR_W-1:31] != {(PR_W-31){est_sum[PR_W-1]}}) begin
            est_r <= est_sum[PR_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
          end else begin
            est_r <= est_sum[VAL_W-1:0];
          end
          if (var_w[PR_W-1]) begin
            var_r <= '0;
          end else if ((var_w >> FRAC_BITS) > PR_W'(MAX31)) begin
            var_r <= MAX31;
          end else begin
            var_r <= VAR_W'(var_w >> FRAC_BITS);
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
          end else begin
            out_valid <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          pp_r  <= pp_nxt;
          y0_r  <= {in_meas_first[31], in_meas_first} - {est_r[31], est_r};
          y1_r  <= {in_meas_second[31], in_meas_second} - {est_r[31], est_r};
          sat_r <= 1'b0;
          k1_r  <= '0;
        end
      end
      S_SGL: begin
        if (s_sum == 32'd0) begin
          k0_r  <= ONE_K;
          k1_r  <= '0;
          sat_r <= 1'b1;
        end
      end
      S_N1:  n0_r  <= rnd_n;
      S_N2:  n1_r  <= rnd_n;
      S_DET: det_r <= DW'(n0_r) + DW'(n1_r) + DW'(rnd_n);
      S_DST: begin
        if (det_r == '0) begin
          k0_r  <= HALF_K;
          k1_r  <= HALF_K;
          sat_r <= 1'b1;
        end
      end
      S_DIV0: if (div_st.done) k0_r <= div_q;
      S_DIV1: if (div_st.done) k1_r <= div_q;
      S_K1:   acc_r <= prod;
      S_ACC:  acc_r <= acc_r + prod;
      S_OUT: begin
        if (!out_valid || out_ready) begin
          out_estimate      <= est_r;
          out_variance      <= var_r;
          out_div_saturated <= sat_r;
        end
      end
      default: ;
    endcase
  end

  // The divider is only started once its previous run has finished.
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_st.busy) else $error("divider restarted while busy");

  // The gains of one update never add up to more than one.
  a_gain_sum: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ACC |-> ({1'b0, k0_r} + {1'b0, k1_r}) <= {1'b0, ONE_K})
    else $error("gain sum above one");

  // A new result only appears out of the result state.
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == S_OUT)) else $error("result from wrong state");

endmodule
`default_nettype wire
